[hw/rtl/bal_pkg.sv]
// ----------------------------------------------------------------------------
// bal_pkg
// Opcodes, status codes and the command/status bundles shared by the
// bounded array list controller and datapath.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        RD_POS,
        RD_LEN_M1,
        RD_POS_P1,
        RD_IDX_M2,
        RD_IDX_P2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_VAL_POS,
        WR_VAL_LEN,
        WR_RDATA_IDX
    } wr_sel_t;

    typedef enum logic {
        IDX_LEN,
        IDX_POS
    } idx_sel_t;

    typedef struct packed {
        logic     load;
        logic     capture;
        logic     mem_rd;
        rd_sel_t  rd_sel;
        logic     mem_wr;
        wr_sel_t  wr_sel;
        logic     idx_load;
        idx_sel_t idx_sel;
        logic     idx_dec;
        logic     idx_inc;
        logic     len_inc;
        logic     len_dec;
    } cmd_t;

    typedef struct packed {
        logic is_get;
        logic is_set;
        logic is_append;
        logic is_insert;
        logic is_delete;
        logic fault;
        logic ins_direct;
        logic del_direct;
        logic ins_more;
        logic del_more;
    } stat_t;

endpackage

[hw/rtl/bal_ctrl.sv]
// ----------------------------------------------------------------------------
// bal_ctrl
// Command sequencer: checks, single accesses, entry moves and the result word.
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bal_pkg::stat_t stat,
    output bal_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import bal_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EVAL     = 6'b000010,
        S_SHIFT_UP = 6'b000100,
        S_SHIFT_DN = 6'b001000,
        S_PLACE    = 6'b010000,
        S_RESP     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = RD_POS;
        cmd.wr_sel  = WR_VAL_POS;
        cmd.idx_sel = IDX_LEN;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
                if (!stat.fault)
                begin
                    priority if (stat.is_get)
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rd_sel = RD_POS;
                    end
                    else if (stat.is_set)
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.wr_sel = WR_VAL_POS;
                    end
                    else if (stat.is_append)
                    begin
                        cmd.mem_wr  = 1'b1;
                        cmd.wr_sel  = WR_VAL_LEN;
                        cmd.len_inc = 1'b1;
                    end
                    else if (stat.is_insert)
                    begin
                        if (stat.ins_direct)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            cmd.mem_rd   = 1'b1;
                            cmd.rd_sel   = RD_LEN_M1;
                            cmd.idx_load = 1'b1;
                            cmd.idx_sel  = IDX_LEN;
                            state_next   = S_SHIFT_UP;
                        end
                    end
                    else if (stat.is_delete)
                    begin
                        if (stat.del_direct)
                        begin
                            cmd.len_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.mem_rd   = 1'b1;
                            cmd.rd_sel   = RD_POS_P1;
                            cmd.idx_load = 1'b1;
                            cmd.idx_sel  = IDX_POS;
                            state_next   = S_SHIFT_DN;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WR_RDATA_IDX;
                cmd.idx_dec = 1'b1;
                if (stat.ins_more)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IDX_M2;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT_DN:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WR_RDATA_IDX;
                cmd.idx_inc = 1'b1;
                if (stat.del_more)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IDX_P2;
                end
                else
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_PLACE:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WR_VAL_POS;
                cmd.len_inc = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

[hw/rtl/bal_dpath.sv]
// ----------------------------------------------------------------------------
// bal_dpath
// Entry memory, length and move index registers, bounds checks and result.
// ----------------------------------------------------------------------------
module bal_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bal_pkg::cmd_t      cmd,
    output bal_pkg::stat_t     stat,
    input  logic [2:0]         opcode,
    input  logic [3:0]         position,
    input  logic signed [31:0] new_value,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [4:0]         list_length
);
    import bal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 4) ? LW : 4;
    localparam int EW = CW + 1;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic [2:0]    op_reg;
    logic [3:0]    pos_reg;
    logic [31:0]   val_reg;
    logic [1:0]    status_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;

    logic [EW-1:0] len_e;
    logic [EW-1:0] pos_e;
    logic [EW-1:0] idx_e;
    logic [EW-1:0] cap_e;
    logic [EW-1:0] rd_addr_e;
    logic [EW-1:0] wr_addr_e;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [1:0]    status_calc;
    logic [LW+4:0] len_wide;

    assign len_e = EW'(len_reg);
    assign pos_e = EW'(pos_reg);
    assign idx_e = EW'(idx_reg);
    assign cap_e = EW'(CAPACITY);

    always_comb
    begin
        status_calc = ST_OK;
        unique case (op_reg)
            OP_GET, OP_SET, OP_DELETE:
            begin
                if (pos_e >= len_e)
                begin
                    status_calc = ST_BOUNDS;
                end
            end
            OP_APPEND:
            begin
                if (len_e >= cap_e)
                begin
                    status_calc = ST_FULL;
                end
            end
            OP_INSERT:
            begin
                priority if (len_e >= cap_e)
                begin
                    status_calc = ST_FULL;
                end
                else if (pos_e > len_e)
                begin
                    status_calc = ST_BOUNDS;
                end
                else
                begin
                    status_calc = ST_OK;
                end
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        stat.is_get     = (op_reg == OP_GET);
        stat.is_set     = (op_reg == OP_SET);
        stat.is_append  = (op_reg == OP_APPEND);
        stat.is_insert  = (op_reg == OP_INSERT);
        stat.is_delete  = (op_reg == OP_DELETE);
        stat.fault      = (status_calc != ST_OK);
        stat.ins_direct = (pos_e == len_e);
        stat.del_direct = ((pos_e + EW'(1)) >= len_e);
        stat.ins_more   = ((idx_e - EW'(1)) > pos_e);
        stat.del_more   = ((idx_e + EW'(2)) < len_e);
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_POS:    rd_addr_e = pos_e;
            RD_LEN_M1: rd_addr_e = len_e - EW'(1);
            RD_POS_P1: rd_addr_e = pos_e + EW'(1);
            RD_IDX_M2: rd_addr_e = idx_e - EW'(2);
            RD_IDX_P2: rd_addr_e = idx_e + EW'(2);
            default:   rd_addr_e = pos_e;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_VAL_POS:
            begin
                wr_addr_e = pos_e;
                wr_data   = val_reg;
            end
            WR_VAL_LEN:
            begin
                wr_addr_e = len_e;
                wr_data   = val_reg;
            end
            WR_RDATA_IDX:
            begin
                wr_addr_e = idx_e;
                wr_data   = rdata_reg;
            end
            default:
            begin
                wr_addr_e = pos_e;
                wr_data   = val_reg;
            end
        endcase
    end

    assign rd_addr = rd_addr_e[AW-1:0];
    assign wr_addr = wr_addr_e[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= new_value;
        end
        if (cmd.capture)
        begin
            status_reg <= status_calc;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        priority if (cmd.len_inc)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (cmd.len_dec)
        begin
            len_next = len_reg - LW'(1);
        end
        else
        begin
            len_next = len_reg;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.idx_load)
        begin
            idx_next = (cmd.idx_sel == IDX_LEN) ? len_e[AW-1:0] : pos_e[AW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            idx_reg <= idx_next;
        end
    end

    assign len_wide    = {5'b0, len_reg};
    assign list_length = len_wide[4:0];
    assign status      = status_reg;
    assign read_value  = ((op_reg == OP_GET) && (status_reg == ST_OK)) ?
                         $signed(rdata_reg) : 32'sd0;

endmodule

[hw/rtl/bounded_array_list_top.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_top
// Ordered list of up to CAPACITY signed 32-bit entries with get, set,
// append, insert and delete commands.
// ----------------------------------------------------------------------------
// channel   direction  handshake          word
// command   in         start, busy        opcode, position, new_value
// result    out        done (one cycle)   read_value, status, list_length
//
// Get, set, append, failed and unused commands pass through the evaluate
// and result states. Insert and delete move one entry per cycle; the entry
// memory reads one entry and writes another in the same cycle. Insert
// evaluates, moves entries up and places the value; delete moves them down.
// busy is high from the cycle after start until done; the next command may
// be given in the cycle after done. Reset clears the length; entries are
// never read before they are written. The result word cannot be stalled.
// ----------------------------------------------------------------------------
module bounded_array_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [3:0]         position,
    input  logic signed [31:0] new_value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [4:0]         list_length
);
    import bal_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bal_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .position    (position),
        .new_value   (new_value),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

endmodule
